FILE: rtl/frame_interval_rate_meter_unit_assert.svh
// ----------------------------------------------------------------------------
// Frame interval rate meter assertion macros
// Immediate-consequence and next-cycle property forms on clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef FRAME_INTERVAL_RATE_METER_UNIT_ASSERT_SVH
`define FRAME_INTERVAL_RATE_METER_UNIT_ASSERT_SVH

`define FRM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define FRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/frm_pkg.sv
// ----------------------------------------------------------------------------
// Frame interval rate meter package
// Sizes, constants, transaction types and divider interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package frm_pkg;

  localparam int HISTORY_DEPTH = 16;
  localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

  localparam int DIV_W         = 32;
  localparam int DIV_CNT_W     = $clog2(DIV_W);

  localparam logic [DIV_W-1:0] RATE_NUM = 32'd256000000;
  localparam logic [DIV_W-1:0] RATE_SAT = 32'hFFFF_FFFF;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_HIST = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] time_us;
  } in_item_t;

  typedef struct packed {
    logic [31:0] avg_interval_us;
    logic [31:0] rate_fps_q8;
    logic [31:0] delta_us;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(HISTORY_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/frame_interval_rate_meter_unit.sv
// ----------------------------------------------------------------------------
// Frame interval rate meter
// First tick only stores; later ticks divide for average interval, then rate.
// Histogram: 15 results; empty slots give zeros, filled ones divide for rate.
// Throughput is set by the shared serial divider; one item in flight. Reset
// is synchronous active low and empties the timestamp ring.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_interval_rate_meter_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire frm_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output frm_pkg::out_item_t      out_data
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_TPREV = 9'b000000010,
    ST_TOLD  = 9'b000000100,
    ST_DIVA  = 9'b000001000,
    ST_DIVR  = 9'b000010000,
    ST_PUT   = 9'b000100000,
    ST_HSLOT = 9'b001000000,
    ST_HRDB  = 9'b010000000,
    ST_HD    = 9'b100000000
  } state_t;

  localparam int SW = frm_pkg::SLOT_W;
  localparam int CW = frm_pkg::CNT_W;

  state_t                state_r, state_nxt;
  logic [SW-1:0]         newest_r, newest_nxt;
  logic [SW-1:0]         oldest_r, oldest_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [31:0]           t_r, t_nxt;
  logic [31:0]           first_r, first_nxt;
  logic [31:0]           delta_r, delta_nxt;
  logic [31:0]           avg_r, avg_nxt;
  logic [31:0]           rate_r, rate_nxt;
  logic                  last_r, last_nxt;
  logic [SW-1:0]         k_r, k_nxt;
  logic [SW-1:0]         miss_r, miss_nxt;
  logic [SW-1:0]         a_r, a_nxt;
  logic                  out_valid_r, out_valid_nxt;
  frm_pkg::out_item_t    out_data_r, out_data_nxt;

  logic [31:0]           stamp_ring [frm_pkg::HISTORY_DEPTH];
  logic [31:0]           rd_data_r;
  logic [SW-1:0]         rd_addr;
  logic                  wr_en;
  logic [SW-1:0]         wr_addr;
  logic [31:0]           wr_data;

  logic [SW-1:0]         intervals;
  logic [31:0]           hist_d;
  frm_pkg::div_req_t     div_req;
  frm_pkg::div_rsp_t     div_rsp;

  frm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    intervals = (count_r == '0) ? '0 : SW'(count_r - 1'b1);
    hist_d    = rd_data_r - first_r;

    state_nxt     = state_r;
    newest_nxt    = newest_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    t_nxt         = t_r;
    first_nxt     = first_r;
    delta_nxt     = delta_r;
    avg_nxt       = avg_r;
    rate_nxt      = rate_r;
    last_nxt      = last_r;
    k_nxt         = k_r;
    miss_nxt      = miss_r;
    a_nxt         = a_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    wr_en            = 1'b0;
    wr_addr          = newest_r;
    wr_data          = t_r;
    rd_addr          = newest_r;
    div_req.start    = 1'b0;
    div_req.dividend = frm_pkg::RATE_NUM;
    div_req.divisor  = delta_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          t_nxt = in_data.time_us;
          if (in_data.op == frm_pkg::OP_TICK) begin
            last_nxt = 1'b1;
            if (count_r == '0) begin
              wr_en      = 1'b1;
              wr_addr    = '0;
              wr_data    = in_data.time_us;
              newest_nxt = '0;
              oldest_nxt = '0;
              count_nxt  = CW'(1);
              avg_nxt    = '0;
              rate_nxt   = '0;
              delta_nxt  = '0;
              state_nxt  = ST_PUT;
            end else begin
              rd_addr   = newest_r;
              state_nxt = ST_TPREV;
            end
          end else begin
            k_nxt     = '0;
            a_nxt     = oldest_r;
            miss_nxt  = SW'(frm_pkg::HISTORY_DEPTH - 1) - intervals;
            state_nxt = ST_HSLOT;
          end
        end
      end
      ST_TPREV: begin
        delta_nxt  = t_r - rd_data_r;
        newest_nxt = frm_pkg::slot_inc(newest_r);
        wr_en      = 1'b1;
        wr_addr    = newest_nxt;
        wr_data    = t_r;
        if (count_r >= CW'(frm_pkg::HISTORY_DEPTH)) begin
          oldest_nxt = frm_pkg::slot_inc(oldest_r);
        end else begin
          count_nxt = count_r + 1'b1;
        end
        rd_addr   = oldest_nxt;
        state_nxt = ST_TOLD;
      end
      ST_TOLD: begin
        div_req.start    = 1'b1;
        div_req.dividend = t_r - rd_data_r;
        div_req.divisor  = 32'(count_r) - 32'd1;
        state_nxt        = ST_DIVA;
      end
      ST_DIVA: begin
        if (div_rsp.done) begin
          avg_nxt = div_rsp.quotient;
          if (div_rsp.quotient == '0) begin
            rate_nxt  = frm_pkg::RATE_SAT;
            state_nxt = ST_PUT;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = frm_pkg::RATE_NUM;
            div_req.divisor  = div_rsp.quotient;
            state_nxt        = ST_DIVR;
          end
        end
      end
      ST_DIVR: begin
        if (div_rsp.done) begin
          rate_nxt  = div_rsp.quotient;
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.avg_interval_us = avg_r;
          out_data_nxt.rate_fps_q8     = rate_r;
          out_data_nxt.delta_us        = delta_r;
          out_data_nxt.last            = last_r;
          if (last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_HSLOT;
          end
        end
      end
      ST_HSLOT: begin
        last_nxt = (k_r == SW'(frm_pkg::HISTORY_DEPTH - 2));
        avg_nxt  = '0;
        if (k_r < miss_r) begin
          rate_nxt  = '0;
          delta_nxt = '0;
          state_nxt = ST_PUT;
        end else begin
          rd_addr   = a_r;
          a_nxt     = frm_pkg::slot_inc(a_r);
          state_nxt = ST_HRDB;
        end
      end
      ST_HRDB: begin
        first_nxt = rd_data_r;
        rd_addr   = a_r;
        state_nxt = ST_HD;
      end
      ST_HD: begin
        delta_nxt = hist_d;
        if (hist_d == '0) begin
          rate_nxt  = frm_pkg::RATE_SAT;
          state_nxt = ST_PUT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = frm_pkg::RATE_NUM;
          div_req.divisor  = hist_d;
          state_nxt        = ST_DIVR;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      newest_r    <= '0;
      oldest_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      newest_r    <= newest_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    first_r    <= first_nxt;
    delta_r    <= delta_nxt;
    avg_r      <= avg_nxt;
    rate_r     <= rate_nxt;
    last_r     <= last_nxt;
    k_r        <= k_nxt;
    miss_r     <= miss_nxt;
    a_r        <= a_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stamp_ring[wr_addr] <= wr_data;
    end
    rd_data_r <= stamp_ring[rd_addr];
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/frm_div.sv
// ----------------------------------------------------------------------------
// Frame interval rate meter serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire frm_pkg::div_req_t req,
  output frm_pkg::div_rsp_t      rsp
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [frm_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [frm_pkg::DIV_W-1:0]      rem_r, rem_nxt;
  logic [frm_pkg::DIV_W-1:0]      quo_r, quo_nxt;
  logic [frm_pkg::DIV_W-1:0]      dvs_r, dvs_nxt;
  logic [frm_pkg::DIV_W:0]        shifted;
  logic [frm_pkg::DIV_W:0]        trial;

  always_comb begin
    shifted  = {rem_r, quo_r[frm_pkg::DIV_W-1]};
    trial    = shifted - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!trial[frm_pkg::DIV_W]) begin
        rem_nxt = trial[frm_pkg::DIV_W-1:0];
        quo_nxt = {quo_r[frm_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[frm_pkg::DIV_W-1:0];
        quo_nxt = {quo_r[frm_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == frm_pkg::DIV_CNT_W'(frm_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

FILE: rtl/frm_chk.sv
// ----------------------------------------------------------------------------
// Frame interval rate meter checker
// Port-level properties of the meter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_interval_rate_meter_unit_assert.svh"

module frm_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire frm_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire frm_pkg::out_item_t out_data
);

  logic in_fire;
  logic out_held;
  logic out_mid;
  logic avg_nz;
  logic rate_ok;

  assign in_fire  = in_valid && !in_stall;
  assign out_held = out_valid && out_stall;
  assign out_mid  = out_valid && !out_data.last;
  assign avg_nz   = out_valid && (out_data.avg_interval_us != 32'd0);
  assign rate_ok  = (out_data.rate_fps_q8 <= frm_pkg::RATE_NUM);

  `FRM_ASSERT_NEXT(a_busy_after_accept, in_fire, in_stall, "input open after a transaction")
  `FRM_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_data), "stalled result changed")
  `FRM_ASSERT_SAME(a_mid_busy, out_mid, in_stall, "input open during a histogram")
  `FRM_ASSERT_SAME(a_rate_bound, avg_nz, rate_ok, "rate above bound for nonzero average")

endmodule

bind frame_interval_rate_meter_unit frm_chk u_frm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
